FILE: sv/cas_pkg.sv
// Package for the cave automaton step core: sizes, register and operation
// codes, and the per-item step record passed from control to datapath.
// No dependencies.
package cas_pkg;

  // Grid limits and field widths
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int DIM_W      = 7;   // grid_width / grid_height registers
  localparam int POS_W      = 6;   // row and column of a result
  localparam int CNT_W      = 4;   // min_count / max_count registers
  localparam int IDX_W      = 2;   // configuration register index
  localparam int CFG_W      = 7;   // widest configuration register
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1,
    REG_MIN_COUNT   = 2'd2,
    REG_MAX_COUNT   = 2'd3
  } cfg_reg_t;

  // Input operation codes
  localparam logic OP_CELL  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Effective grid size after clamping
  typedef struct packed {
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
  } dims_t;

  // What one accepted item does, and the metadata of its result
  typedef struct packed {
    logic             push;
    logic             push_bit;
    logic             emit;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             last;
    logic             top_ok;
    logic             bot_ok;
    logic             left_ok;
    logic             right_ok;
    logic             degen;     // single-row grid: result trails by w only
    logic [CNT_W-1:0] min_cnt;
    logic [CNT_W-1:0] max_cnt;
  } step_t;

  // 0 acts as 1, above the limit acts as the limit
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: sv/cas_cell.sv
// One storage cell of a variable-length line buffer.
// Depends on nothing; used by cas_line.
module cas_cell (
  input  logic clk,
  input  logic shift,     // an item is pushed this cycle
  input  logic is_tail,   // this cell is the insertion point for the set width
  input  logic head_bit,  // bit entering the line
  input  logic next_bit,  // bit held by the upstream neighbor
  output logic q
);

  logic q_r, q_nxt;

  // Take the new bit at the insertion point, else the neighbor's bit
  always_comb begin
    q_nxt = q_r;
    if (shift) begin
      q_nxt = is_tail ? head_bit : next_bit;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

FILE: sv/cas_line.sv
// Line buffer of MAX_WIDTH cells whose active length follows the grid width.
// Depends on cas_pkg and cas_cell.
module cas_line (
  input  logic                      clk,
  input  logic                      shift,
  input  logic [cas_pkg::DIM_W-1:0] len,       // active cells, 1..MAX_WIDTH
  input  logic                      head_bit,
  output logic                      tail_bit   // bit pushed len-1 items ago
);

  logic [cas_pkg::MAX_WIDTH-1:0] q;

  // Cell k is the insertion point when len == k+1; bits move toward cell 0
  for (genvar k = 0; k < cas_pkg::MAX_WIDTH; k++) begin : g_cell
    logic nb;
    if (k == cas_pkg::MAX_WIDTH - 1) begin : g_end
      assign nb = 1'b0;
    end else begin : g_mid
      assign nb = q[k+1];
    end
    cas_cell u_cell (
      .clk      (clk),
      .shift    (shift),
      .is_tail  (len == cas_pkg::DIM_W'(k + 1)),
      .head_bit (head_bit),
      .next_bit (nb),
      .q        (q[k])
    );
  end

  assign tail_bit = q[0];

endmodule

FILE: sv/cas_ctrl.sv
// Control of the cave automaton step: configuration registers, raster
// counters for input and results, and the per-item step decision.
// Depends on cas_pkg.
module cas_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      acc,        // input item accepted
  input  logic                      op,
  input  logic                      cell_wall,
  input  logic                      cfg_we,
  input  logic [cas_pkg::IDX_W-1:0] cfg_index,
  input  logic [cas_pkg::CFG_W-1:0] cfg_wdata,
  output cas_pkg::step_t            step,
  output cas_pkg::dims_t            dims
);

  logic [cas_pkg::DIM_W-1:0] w_r, w_nxt, h_r, h_nxt;
  logic [cas_pkg::CNT_W-1:0] min_r, min_nxt, max_r, max_nxt;
  logic [cas_pkg::POS_W-1:0] in_col_r, in_col_nxt, in_row_r, in_row_nxt;
  logic [cas_pkg::POS_W-1:0] out_col_r, out_col_nxt, out_row_r, out_row_nxt;
  logic                      in_done_r, in_done_nxt;
  logic [cas_pkg::DIM_W-1:0] pend_r, pend_nxt;   // cells in but not yet out

  logic [cas_pkg::DIM_W-1:0] w_eff, h_eff, w_m1, h_m1;
  logic in_col_end, in_row_end, out_col_end, out_row_end, pend_full;
  logic restart;

  // Clamped geometry and end-of-row/frame tests
  always_comb begin
    w_eff       = cas_pkg::clamp_dim(w_r, cas_pkg::DIM_W'(cas_pkg::MAX_WIDTH));
    h_eff       = cas_pkg::clamp_dim(h_r, cas_pkg::DIM_W'(cas_pkg::MAX_HEIGHT));
    w_m1        = w_eff - cas_pkg::DIM_W'(1);
    h_m1        = h_eff - cas_pkg::DIM_W'(1);
    in_col_end  = {1'b0, in_col_r} == w_m1;
    in_row_end  = {1'b0, in_row_r} == h_m1;
    out_col_end = {1'b0, out_col_r} == w_m1;
    out_row_end = {1'b0, out_row_r} == h_m1;
    pend_full   = pend_r == (w_eff + cas_pkg::DIM_W'(1));
  end

  // Step decision: cells push until the frame is in, each releasing a result
  // once w_eff+1 are pending; afterwards every item pushes a clear cell and releases one result
  always_comb begin
    step          = '0;
    step.push     = acc && (in_done_r || (op == cas_pkg::OP_CELL));
    step.push_bit = in_done_r ? 1'b0 : cell_wall;
    step.emit     = acc && (in_done_r || ((op == cas_pkg::OP_CELL) && pend_full));
    step.col      = out_col_r;
    step.row      = out_row_r;
    step.last     = out_row_end && out_col_end;
    step.top_ok   = out_row_r != '0;
    step.bot_ok   = !out_row_end;
    step.left_ok  = out_col_r != '0;
    step.right_ok = !out_col_end;
    step.degen    = h_eff == cas_pkg::DIM_W'(1);
    step.min_cnt  = min_r;
    step.max_cnt  = max_r;
    dims.w_eff    = w_eff;
    dims.h_eff    = h_eff;
  end

  // Next state
  always_comb begin
    w_nxt       = w_r;
    h_nxt       = h_r;
    min_nxt     = min_r;
    max_nxt     = max_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    in_done_nxt = in_done_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    pend_nxt    = pend_r;
    restart     = 1'b0;

    if (cfg_we) begin
      restart = 1'b1;
      case (cas_pkg::cfg_reg_t'(cfg_index))
        cas_pkg::REG_GRID_WIDTH:  w_nxt   = cfg_wdata[cas_pkg::DIM_W-1:0];
        cas_pkg::REG_GRID_HEIGHT: h_nxt   = cfg_wdata[cas_pkg::DIM_W-1:0];
        cas_pkg::REG_MIN_COUNT:   min_nxt = cfg_wdata[cas_pkg::CNT_W-1:0];
        cas_pkg::REG_MAX_COUNT:   max_nxt = cfg_wdata[cas_pkg::CNT_W-1:0];
        default:                  restart = 1'b0;
      endcase
    end else if (step.emit && step.last) begin
      restart = 1'b1;
    end else begin
      // input raster position
      if (step.push && !in_done_r) begin
        if (in_col_end) begin
          in_col_nxt = '0;
          if (in_row_end) begin
            in_done_nxt = 1'b1;
          end else begin
            in_row_nxt = in_row_r + cas_pkg::POS_W'(1);
          end
        end else begin
          in_col_nxt = in_col_r + cas_pkg::POS_W'(1);
        end
      end
      // result raster position
      if (step.emit) begin
        if (out_col_end) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + cas_pkg::POS_W'(1);
        end else begin
          out_col_nxt = out_col_r + cas_pkg::POS_W'(1);
        end
      end
      if (step.push && !step.emit) begin
        pend_nxt = pend_r + cas_pkg::DIM_W'(1);
      end
    end

    if (restart) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      in_done_nxt = 1'b0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      pend_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r       <= cas_pkg::DIM_W'(50);
      h_r       <= cas_pkg::DIM_W'(50);
      min_r     <= cas_pkg::CNT_W'(3);
      max_r     <= cas_pkg::CNT_W'(5);
      in_col_r  <= '0;
      in_row_r  <= '0;
      in_done_r <= 1'b0;
      out_col_r <= '0;
      out_row_r <= '0;
      pend_r    <= '0;
    end else begin
      w_r       <= w_nxt;
      h_r       <= h_nxt;
      min_r     <= min_nxt;
      max_r     <= max_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      in_done_r <= in_done_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      pend_r    <= pend_nxt;
    end
  end

endmodule

FILE: sv/cas_top_doc_placeholder.sv
// Window evaluation stage: masks the 3x3 neighborhood at the grid border,
// counts walls and applies the count band.
// Depends on cas_pkg.
module cas_eval (
  input  cas_pkg::step_t p,
  input  logic [2:0]     row_up,    // dc = -1, 0, +1 at bit 2, 1, 0
  input  logic [2:0]     row_mid,
  input  logic [2:0]     row_dn,
  output logic           wall
);

  logic [8:0] win;
  logic [3:0] cnt;

  // Border mask: outside cells count as clear
  always_comb begin
    win[8] = row_up[2]  && p.top_ok && p.left_ok;
    win[7] = row_up[1]  && p.top_ok;
    win[6] = row_up[0]  && p.top_ok && p.right_ok;
    win[5] = row_mid[2] && p.left_ok;
    win[4] = row_mid[1];
    win[3] = row_mid[0] && p.right_ok;
    win[2] = row_dn[2]  && p.bot_ok && p.left_ok;
    win[1] = row_dn[1]  && p.bot_ok;
    win[0] = row_dn[0]  && p.bot_ok && p.right_ok;
    cnt = '0;
    for (int i = 0; i < 9; i++) begin
      cnt = cnt + {3'b000, win[i]};
    end
    wall = (cnt >= p.min_cnt) && (cnt <= p.max_cnt);
  end

endmodule

FILE: sv/cave_automaton_step_core.sv
// Top level of the cave automaton step core: line buffers, window taps,
// evaluation stage and output register.
// Depends on cas_pkg, cas_line, cas_ctrl and cas_eval.
//
//  channel | ports                     | contents
//  --------+---------------------------+--------------------------------------
//  input   | in_tvalid/tready/tdata/tuser | tuser: operation; tdata: cell_wall
//  output  | out_tvalid/tready/tdata/tlast | tdata: new_wall, col, row; tlast: frame_last
//  config  | cfg_we/cfg_index/cfg_wdata | grid_width, grid_height, min/max_count
//
// One item per cycle while in_tready is high. A result is computed in the cycle after
// the item that releases it and is loaded into the output register once that is free;
// the result for a cell trails its input by grid_width+1 items (grid_width on a
// single-row grid). Two line buffers of MAX_WIDTH cells set the row delay.
// Reset clears control and counters only; no clearing pass. in_tready drops
// only while a computed result waits behind a stalled output register.
module cave_automaton_step_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [cas_pkg::IN_DATA_W-1:0]  in_tdata,   // [0] cell_wall
  input  logic                           in_tuser,   // [0] operation
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [cas_pkg::OUT_DATA_W-1:0] out_tdata,  // [0] new_wall, [6:1] col, [12:7] row
  output logic                           out_tlast,
  input  logic                           cfg_we,
  input  logic [cas_pkg::IDX_W-1:0]      cfg_index,
  input  logic [cas_pkg::CFG_W-1:0]      cfg_wdata
);

  cas_pkg::step_t step;
  cas_pkg::dims_t dims;
  logic           in_acc;

  cas_pkg::step_t p_r, p_nxt;
  logic           p_vld_r, p_vld_nxt;
  logic           o_vld_r, o_vld_nxt;
  logic           o_wall_r, o_wall_nxt, o_last_r, o_last_nxt;
  logic [cas_pkg::POS_W-1:0] o_col_r, o_col_nxt, o_row_r, o_row_nxt;
  logic           o_load_ok, p_move;

  logic [2:0] r0_r, r0_nxt, r1_r, r1_nxt, r2_r, r2_nxt;
  logic       a_tail, b_tail;
  logic [2:0] row_mid;
  logic       wall;

  // Handshake
  assign o_load_ok = !o_vld_r || out_tready;
  assign p_move    = p_vld_r && o_load_ok;
  assign in_tready = !p_vld_r || o_load_ok;
  assign in_acc    = in_tvalid && in_tready;

  cas_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .op        (in_tuser),
    .cell_wall (in_tdata[0]),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .dims      (dims)
  );

  // Row delay lines: A holds ages 0..w-1, B ages w..2w-1
  cas_line u_line_a (
    .clk      (clk),
    .shift    (step.push),
    .len      (dims.w_eff),
    .head_bit (step.push_bit),
    .tail_bit (a_tail)
  );

  cas_line u_line_b (
    .clk      (clk),
    .shift    (step.push),
    .len      (dims.w_eff),
    .head_bit (a_tail),
    .tail_bit (b_tail)
  );

  // Window taps: r0 ages 0..2, r1 ages w..w+2, r2 ages 2w..2w+2
  always_comb begin
    r0_nxt = r0_r;
    r1_nxt = r1_r;
    r2_nxt = r2_r;
    if (step.push) begin
      r0_nxt = {r0_r[1:0], step.push_bit};
      r1_nxt = {r1_r[1:0], a_tail};
      r2_nxt = {r2_r[1:0], b_tail};
    end
  end

  always_ff @(posedge clk) begin
    r0_r <= r0_nxt;
    r1_r <= r1_nxt;
    r2_r <= r2_nxt;
  end

  // Single-row grid: the middle row sits one age nearer
  assign row_mid = p_r.degen ? {r1_r[1], r1_r[0], a_tail} : r1_r;

  cas_eval u_eval (
    .p       (p_r),
    .row_up  (r2_r),
    .row_mid (row_mid),
    .row_dn  (r0_r),
    .wall    (wall)
  );

  // Evaluation stage and output register
  always_comb begin
    p_nxt      = p_r;
    p_vld_nxt  = p_vld_r;
    o_vld_nxt  = o_vld_r;
    o_wall_nxt = o_wall_r;
    o_col_nxt  = o_col_r;
    o_row_nxt  = o_row_r;
    o_last_nxt = o_last_r;
    if (in_acc) begin
      p_nxt     = step;
      p_vld_nxt = step.emit;
    end else if (p_move) begin
      p_vld_nxt = 1'b0;
    end
    if (p_move) begin
      o_vld_nxt  = 1'b1;
      o_wall_nxt = wall;
      o_col_nxt  = p_r.col;
      o_row_nxt  = p_r.row;
      o_last_nxt = p_r.last;
    end else if (out_tready) begin
      o_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      p_vld_r <= p_vld_nxt;
      o_vld_r <= o_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r      <= p_nxt;
    o_wall_r <= o_wall_nxt;
    o_col_r  <= o_col_nxt;
    o_row_r  <= o_row_nxt;
    o_last_r <= o_last_nxt;
  end

  assign out_tvalid = o_vld_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {3'b000, o_row_r, o_col_r, o_wall_r};

`ifndef NO_ASSERTIONS
  // Input stalls only behind a blocked output register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without output back-pressure");

  // A computed result is held while the output register is blocked
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (p_vld_r && out_tvalid && !out_tready) |=> p_vld_r)
    else $error("evaluation stage lost a result");

  // The frame-last flag marks the bottom-right cell
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |->
      (({1'b0, o_row_r} == dims.h_eff - cas_pkg::DIM_W'(1)) &&
       ({1'b0, o_col_r} == dims.w_eff - cas_pkg::DIM_W'(1))))
    else $error("frame_last on a cell other than the last");
`endif

endmodule
